[design/kmpt_pkg.sv]
// kmpt_pkg: operation and status codes and control structs for the keyed
// max priority table; no dependencies
package kmpt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic rd_en;
        logic id_we;
        logic prio_we;
        logic set_valid;
        logic taken_clr;
        logic taken_set;
    } store_cmd_t;

    typedef struct packed {
        logic found;
        logic free_found;
        logic best_found;
    } scan_flags_t;

endpackage

[design/keyed_max_priority_table.sv]
// keyed_max_priority_table: top level sequencer of the keyed max priority
// table; uses kmpt_pkg, kmpt_store and kmpt_cmp
//
// channel  | handshake            | word
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_stall  | operation, entry_id, priority_req
// output   | out_valid / out_stall| status, out_id, out_priority, last
//
// every operation is one scan of all CAPACITY slots through the memory read
// port and the compare unit, passing through the scan, tail and result steps;
// the next word is accepted only once the sequencer is back in idle; a list of
// n entries rescans once per word emitted.
// in_stall is high from acceptance until the final result is loaded into
// the output register; a stalled output holds the sequencer in its result step
// reset clears valid bits and entry count at once; no clearing pass
module keyed_max_priority_table
    import kmpt_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [ID_BITS-1:0]       entry_id,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [ID_BITS-1:0]       out_id,
    output logic [PRIORITY_BITS-1:0] out_priority,
    output logic                     last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_TAIL   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [IDX_W-1:0]         scan_reg;
    logic [IDX_W-1:0]         scan_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic [1:0]               op_reg;
    logic [ID_BITS-1:0]       key_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [2:0]               status_reg;
    logic [ID_BITS-1:0]       out_id_reg;
    logic [PRIORITY_BITS-1:0] out_prio_reg;
    logic                     last_reg;

    logic                     accept;
    logic                     out_free;
    logic                     load;
    logic                     start;
    logic [2:0]               res_status;
    logic [ID_BITS-1:0]       res_id;
    logic [PRIORITY_BITS-1:0] res_prio;
    logic                     res_last;

    store_cmd_t               cmd;
    logic [IDX_W-1:0]         wr_idx;

    logic                     rd_vld;
    logic [IDX_W-1:0]         rd_idx_q;
    logic [ID_BITS-1:0]       rd_id;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     rd_used;
    logic                     rd_live;
    scan_flags_t              flags;
    logic [IDX_W-1:0]         found_idx;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         best_idx;
    logic [ID_BITS-1:0]       best_id;
    logic [PRIORITY_BITS-1:0] best_prio;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        cmd         = '0;
        wr_idx      = free_idx;
        load        = 1'b0;
        start       = 1'b0;
        res_status  = ST_OK;
        res_id      = key_reg;
        res_prio    = prio_reg;
        res_last    = 1'b1;

        unique case (op_reg)
            OP_INSERT:
            begin
                if (flags.found)
                begin
                    res_status = ST_DUPLICATE;
                    res_prio   = '0;
                end
                else if (!flags.free_found)
                begin
                    res_status = ST_FULL;
                    res_prio   = '0;
                end
            end
            OP_UPDATE:
            begin
                wr_idx = found_idx;
                if (!flags.found)
                begin
                    res_status = ST_NOT_FOUND;
                    res_prio   = '0;
                end
            end
            OP_PEEK, OP_LIST:
            begin
                if (!flags.best_found)
                begin
                    res_status = ST_EMPTY;
                    res_id     = '0;
                    res_prio   = '0;
                end
                else
                begin
                    res_id   = best_id;
                    res_prio = best_prio;
                    res_last = (op_reg == OP_PEEK) || (remain_reg <= CNT_W'(1));
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start         = 1'b1;
                    scan_next     = '0;
                    remain_next   = count_reg;
                    cmd.taken_clr = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (scan_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_TAIL:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_INSERT && !flags.found && flags.free_found)
                    begin
                        cmd.id_we     = 1'b1;
                        cmd.prio_we   = 1'b1;
                        cmd.set_valid = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if (op_reg == OP_UPDATE && flags.found)
                    begin
                        cmd.prio_we = 1'b1;
                    end
                    // rescan for the next entry of a list
                    if (op_reg == OP_LIST && !res_last)
                    begin
                        cmd.taken_set = 1'b1;
                        remain_next   = remain_reg - CNT_W'(1);
                        start         = 1'b1;
                        scan_next     = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            key_reg  <= entry_id;
            prio_reg <= priority_req;
        end
        if (load)
        begin
            status_reg   <= res_status;
            out_id_reg   <= res_id;
            out_prio_reg <= res_prio;
            last_reg     <= res_last;
        end
    end

    kmpt_store #(
        .CAPACITY      (CAPACITY),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_idx    (scan_reg),
        .wr_idx    (wr_idx),
        .wr_id     (key_reg),
        .wr_prio   (prio_reg),
        .taken_idx (best_idx),
        .rd_vld    (rd_vld),
        .rd_idx_q  (rd_idx_q),
        .rd_id     (rd_id),
        .rd_prio   (rd_prio),
        .rd_used   (rd_used),
        .rd_live   (rd_live)
    );

    kmpt_cmp #(
        .IDX_W         (IDX_W),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .key_id    (key_reg),
        .rd_vld    (rd_vld),
        .rd_idx    (rd_idx_q),
        .rd_id     (rd_id),
        .rd_prio   (rd_prio),
        .rd_used   (rd_used),
        .rd_live   (rd_live),
        .flags     (flags),
        .found_idx (found_idx),
        .free_idx  (free_idx),
        .best_idx  (best_idx),
        .best_id   (best_id),
        .best_prio (best_prio)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_prio_reg;
    assign last         = last_reg;

endmodule

[design/kmpt_store.sv]
// kmpt_store: slot id and priority memories with registered read, plus
// per-slot valid and taken flops; depends on kmpt_pkg
module kmpt_store
    import kmpt_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  store_cmd_t                   cmd,
    input  logic [$clog2(CAPACITY)-1:0]  rd_idx,
    input  logic [$clog2(CAPACITY)-1:0]  wr_idx,
    input  logic [ID_BITS-1:0]           wr_id,
    input  logic [PRIORITY_BITS-1:0]     wr_prio,
    input  logic [$clog2(CAPACITY)-1:0]  taken_idx,
    output logic                         rd_vld,
    output logic [$clog2(CAPACITY)-1:0]  rd_idx_q,
    output logic [ID_BITS-1:0]           rd_id,
    output logic [PRIORITY_BITS-1:0]     rd_prio,
    output logic                         rd_used,
    output logic                         rd_live
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [ID_BITS-1:0]       mem_id   [CAPACITY];
    logic [PRIORITY_BITS-1:0] mem_prio [CAPACITY];

    logic [CAPACITY-1:0]      valid_reg;
    logic [CAPACITY-1:0]      valid_next;
    logic [CAPACITY-1:0]      taken_reg;
    logic [CAPACITY-1:0]      taken_next;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [ID_BITS-1:0]       rd_id_reg;
    logic [PRIORITY_BITS-1:0] rd_prio_reg;
    logic                     rd_used_reg;
    logic                     rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.id_we)
        begin
            mem_id[wr_idx] <= wr_id;
        end
        if (cmd.prio_we)
        begin
            mem_prio[wr_idx] <= wr_prio;
        end
        rd_id_reg   <= mem_id[rd_idx];
        rd_prio_reg <= mem_prio[rd_idx];
        rd_idx_reg  <= rd_idx;
        rd_used_reg <= valid_reg[rd_idx];
        rd_live_reg <= valid_reg[rd_idx] & ~taken_reg[rd_idx];
    end

    always_comb
    begin
        valid_next = valid_reg;
        taken_next = taken_reg;
        if (cmd.set_valid)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cmd.taken_clr)
        begin
            taken_next = '0;
        end
        else if (cmd.taken_set)
        begin
            taken_next[taken_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            taken_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            taken_reg  <= taken_next;
            rd_vld_reg <= cmd.rd_en;
        end
    end

    assign rd_vld   = rd_vld_reg;
    assign rd_idx_q = rd_idx_reg;
    assign rd_id    = rd_id_reg;
    assign rd_prio  = rd_prio_reg;
    assign rd_used  = rd_used_reg;
    assign rd_live  = rd_live_reg;

endmodule

[design/kmpt_cmp.sv]
// kmpt_cmp: shared compare unit, one slot per cycle; tracks id match,
// first free slot and running maximum; depends on kmpt_pkg
module kmpt_cmp
    import kmpt_pkg::*;
#(
    parameter int IDX_W         = 5,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ID_BITS-1:0]       key_id,
    input  logic                     rd_vld,
    input  logic [IDX_W-1:0]         rd_idx,
    input  logic [ID_BITS-1:0]       rd_id,
    input  logic [PRIORITY_BITS-1:0] rd_prio,
    input  logic                     rd_used,
    input  logic                     rd_live,
    output scan_flags_t              flags,
    output logic [IDX_W-1:0]         found_idx,
    output logic [IDX_W-1:0]         free_idx,
    output logic [IDX_W-1:0]         best_idx,
    output logic [ID_BITS-1:0]       best_id,
    output logic [PRIORITY_BITS-1:0] best_prio
);

    scan_flags_t              flags_reg;
    scan_flags_t              flags_next;
    logic [IDX_W-1:0]         found_idx_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [ID_BITS-1:0]       best_id_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic                     hit;
    logic                     free_hit;
    logic                     best_hit;

    always_comb
    begin
        hit      = rd_vld & rd_used & (rd_id == key_id) & ~flags_reg.found;
        free_hit = rd_vld & ~rd_used & ~flags_reg.free_found;
        // strict compare keeps the lower slot on a tie
        best_hit = rd_vld & rd_live & (~flags_reg.best_found | (rd_prio > best_prio_reg));
        flags_next = flags_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else
        begin
            if (hit)
            begin
                flags_next.found = 1'b1;
            end
            if (free_hit)
            begin
                flags_next.free_found = 1'b1;
            end
            if (best_hit)
            begin
                flags_next.best_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!start && hit)
        begin
            found_idx_reg <= rd_idx;
        end
        if (!start && free_hit)
        begin
            free_idx_reg <= rd_idx;
        end
        if (!start && best_hit)
        begin
            best_idx_reg  <= rd_idx;
            best_id_reg   <= rd_id;
            best_prio_reg <= rd_prio;
        end
    end

    assign flags     = flags_reg;
    assign found_idx = found_idx_reg;
    assign free_idx  = free_idx_reg;
    assign best_idx  = best_idx_reg;
    assign best_id   = best_id_reg;
    assign best_prio = best_prio_reg;

endmodule
